@@ hw/rtl/rsd_pkg.sv @@
// Shared types and constants for the rounding signed divider.
package rsd_pkg;

    localparam int WIDTH = 32;

    localparam logic [1:0] MODE_CEIL  = 2'd0;
    localparam logic [1:0] MODE_FLOOR = 2'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [WIDTH-1:0] dividend;
        logic signed [WIDTH-1:0] divisor;
    } rsd_in_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] quotient;
        logic [1:0]              status;
    } rsd_out_t;

    // One slot of the bit-per-stage divide pipeline.
    typedef struct packed {
        logic             neg;
        logic             divzero;
        logic [1:0]       mode;
        logic [WIDTH-1:0] dm;
        logic [WIDTH-1:0] rem;
        logic [WIDTH-1:0] nq;
    } rsd_stage_t;

    // Rounding stage result.
    typedef struct packed {
        logic             neg;
        logic             divzero;
        logic [WIDTH-1:0] q;
    } rsd_round_t;

endpackage

@@ hw/rtl/rounding_signed_divider_core.sv @@
// Pipelined signed divider with ceiling, floor and nearest rounding.
//
// Usage
//   Input channel s_valid/s_ready/s_payload carries one transaction per operand
//   set: op (0 ceiling, 1 floor, 2 or 3 nearest with ties away from zero),
//   dividend and divisor, both two's complement. Result channel
//   m_valid/m_ready/m_payload returns the rounded quotient and a status:
//   0 ok, 1 divide by zero (quotient 0), 2 overflow (quotient saturated).
//   Results leave in the order the transactions arrived, one per input.
// Pipeline and throughput
//   An input passes through the magnitude stage, one restoring divide step
//   per quotient bit, a stage to round and a stage to apply the sign and
//   saturate before it shows on m_valid. One transaction enters per cycle
//   while the output moves.
// Stall behaviour
//   The whole pipeline advances together. When a result waits on m_valid and
//   m_ready is low, every stage holds and s_ready drops; nothing is lost
//   or repeated.
// Reset
//   aresetn is synchronous, active low, and clears every stage valid bit.
module rounding_signed_divider_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rsd_pkg::rsd_in_t  s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output rsd_pkg::rsd_out_t m_payload
);

    localparam int W = rsd_pkg::WIDTH;

    // Global advance: every stage moves when the output slot is free or taken.
    logic adv;
    logic s_accept;

    // Stage 0 holds magnitudes; stage k+1 holds the result of divide step k.
    rsd_pkg::rsd_stage_t stage_reg [0:W];
    logic                vld_reg   [0:W];

    rsd_pkg::rsd_stage_t stage0_next;

    rsd_pkg::rsd_round_t round_reg;
    rsd_pkg::rsd_round_t round_next;
    logic                round_vld_reg;

    rsd_pkg::rsd_out_t   out_reg;
    rsd_pkg::rsd_out_t   out_next;
    logic                out_vld_reg;

    assign adv      = !out_vld_reg || m_ready;
    assign s_ready  = adv;
    assign s_accept = s_valid && adv;

    assign m_valid   = out_vld_reg;
    assign m_payload = out_reg;

    // ---------------------------------------------------------------
    // Entry: take magnitudes of both operands, note sign and zero divisor.
    // ---------------------------------------------------------------
    always_comb begin
        logic nneg;
        logic dneg;
        nneg = s_payload.dividend[W-1];
        dneg = s_payload.divisor[W-1];
        stage0_next.neg     = nneg ^ dneg;
        stage0_next.divzero = (s_payload.divisor == '0);
        stage0_next.mode    = s_payload.op;
        stage0_next.nq      = nneg ? (~s_payload.dividend + 1'b1) : s_payload.dividend;
        stage0_next.dm      = dneg ? (~s_payload.divisor + 1'b1) : s_payload.divisor;
        stage0_next.rem     = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg[0] <= stage0_next;
        end
    end

    // ---------------------------------------------------------------
    // Restoring divide: one quotient bit per stage. nq shifts dividend
    // bits out at the top and quotient bits in at the bottom.
    // ---------------------------------------------------------------
    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0]          part;
        logic [W:0]          trial;
        rsd_pkg::rsd_stage_t step_next;

        always_comb begin
            part  = {stage_reg[k].rem, stage_reg[k].nq[W-1]};
            trial = part - {1'b0, stage_reg[k].dm};
            step_next = stage_reg[k];
            if (!trial[W]) begin
                step_next.rem = trial[W-1:0];
                step_next.nq  = {stage_reg[k].nq[W-2:0], 1'b1};
            end else begin
                step_next.rem = part[W-1:0];
                step_next.nq  = {stage_reg[k].nq[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                stage_reg[k+1] <= step_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Round: bump the truncated magnitude when the mode calls for it.
    // For a non-zero divisor the magnitude is at most 2^(W-1), so the bump cannot wrap.
    // ---------------------------------------------------------------
    always_comb begin
        logic inc;
        logic rnz;
        rnz = (stage_reg[W].rem != '0);
        case (stage_reg[W].mode)
            rsd_pkg::MODE_CEIL:  inc = rnz && !stage_reg[W].neg;
            rsd_pkg::MODE_FLOOR: inc = rnz && stage_reg[W].neg;
            default:             inc = rnz &&
                ({stage_reg[W].rem, 1'b0} >= {1'b0, stage_reg[W].dm});
        endcase
        round_next.neg     = stage_reg[W].neg;
        round_next.divzero = stage_reg[W].divzero;
        round_next.q       = stage_reg[W].nq + {{(W-1){1'b0}}, inc};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_vld_reg <= 1'b0;
        end else if (adv) begin
            round_vld_reg <= vld_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            round_reg <= round_next;
        end
    end

    // ---------------------------------------------------------------
    // Sign and saturate, flag divide by zero.
    // ---------------------------------------------------------------
    always_comb begin
        logic [W-1:0] smin;
        logic [W-1:0] smax;
        smin = {1'b1, {(W-1){1'b0}}};
        smax = {1'b0, {(W-1){1'b1}}};
        out_next.status = rsd_pkg::ST_OK;
        if (round_reg.divzero) begin
            out_next.quotient = '0;
            out_next.status   = rsd_pkg::ST_DIVZERO;
        end else if (round_reg.neg) begin
            if (round_reg.q > smin) begin
                out_next.quotient = smin;
                out_next.status   = rsd_pkg::ST_OVERFLOW;
            end else begin
                out_next.quotient = ~round_reg.q + 1'b1;
            end
        end else begin
            if (round_reg.q > smax) begin
                out_next.quotient = smax;
                out_next.status   = rsd_pkg::ST_OVERFLOW;
            end else begin
                out_next.quotient = round_reg.q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= round_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_entry_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> (vld_reg[W] == $past(vld_reg[W])) && $stable(round_vld_reg))
        else $error("pipeline moved during a stall");

    a_divzero_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status == rsd_pkg::ST_DIVZERO) |-> (m_payload.quotient == '0))
        else $error("divide by zero with non-zero quotient");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status == rsd_pkg::ST_OVERFLOW) |->
            (m_payload.quotient == {1'b0, {(W-1){1'b1}}}) ||
            (m_payload.quotient == {1'b1, {(W-1){1'b0}}}))
        else $error("overflow status without a saturated quotient");

endmodule
